/* rtl/qbn_pkg.sv */
// Package for the quadratic Bezier nearest-point block: widths, format constants,
// handshake structs between the sequencer and its arithmetic units, Horner coefficients.
// No dependencies.
`default_nettype none
package qbn_pkg;

	localparam int FRAC_BITS        = 16;
	localparam int MAX_NEWTON_STEPS = 16;

	localparam int T_W       = FRAC_BITS + 1;              // t in [0,1]
	localparam int Q_W       = FRAC_BITS + 2;              // quotient, saturates at 2
	localparam int NT_W      = FRAC_BITS + 4;              // signed t +/- quotient
	localparam int N_W       = $clog2(MAX_NEWTON_STEPS + 1);
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int V_W       = 35;                         // A, B, V components
	localparam int W_W       = 29;                         // scaled components, |w| <= 2^27
	localparam int LIMIT_LOG2 = 27;
	localparam int TOL_W     = 16;
	localparam int K_PRODUCTS = 10;

	// moves between Q0.16 and the t format
	localparam int FMT_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int FMT_DN = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

	localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

	typedef logic signed [63:0] word_t;

	typedef enum logic [1:0] {
		POLY_CUBIC,
		POLY_SLOPE,
		POLY_QUART
	} poly_t;

	typedef struct packed {
		logic        start;
		word_t       a;
		logic [31:0] b;
		logic        neg;
		logic        shr;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] mag;
		logic        neg;
	} mul_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic           done;
		logic [Q_W-1:0] quot;
	} div_rsp_t;

	function automatic logic [2:0] poly_degree(input poly_t kind);
		logic [2:0] d;
		unique case (kind)
			POLY_CUBIC: d = 3'd3;
			POLY_SLOPE: d = 3'd2;
			POLY_QUART: d = 3'd4;
			default:    d = 3'd3;
		endcase
		return d;
	endfunction

	// Horner coefficient idx (highest power first)
	function automatic word_t horner_coef(input poly_t kind, input logic [2:0] idx,
			input word_t k0, input word_t k1, input word_t k2, input word_t k3);
		word_t c;
		c = '0;
		unique case (kind)
			POLY_CUBIC: begin
				unique case (idx)
					3'd0:    c = k0;
					3'd1:    c = k1;
					3'd2:    c = k2;
					3'd3:    c = k3;
					default: c = '0;
				endcase
			end
			POLY_SLOPE: begin
				unique case (idx)
					3'd0:    c = k0 + (k0 <<< 1);
					3'd1:    c = k1 <<< 1;
					3'd2:    c = k2;
					default: c = '0;
				endcase
			end
			POLY_QUART: begin
				unique case (idx)
					3'd0:    c = k0 + (k0 <<< 1);
					3'd1:    c = k1 <<< 2;
					3'd2:    c = (k2 <<< 2) + (k2 <<< 1);
					3'd3:    c = (k3 <<< 3) + (k3 <<< 2);
					default: c = '0;
				endcase
			end
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/quadratic_bezier_nearest_vector.sv */
// Nearest point on a quadratic Bezier curve by Newton iteration; top level and sequencer.
// One item at a time: setup (shift search, ten coefficient products, start choice),
// up to MAX_NEWTON_STEPS Newton steps, then the endpoint check and output vector.
// Every product goes through the shared multiplier and every quotient through the divider;
// a new item is taken only once the previous result has been accepted.
// Reset: async active low; tolerance returns to 16, sequencer idle, no result pending.
`default_nettype none
module quadratic_bezier_nearest_vector
	import qbn_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// input item
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_x, point_y, start_x, start_y, ctrl_x, ctrl_y, finish_x, finish_y (32 b each)
	input  logic [255:0] s_tdata,
	// result item
	output logic         m_tvalid,
	input  logic         m_tready,
	// vec_x[31:0], vec_y[63:32], curve_param[80:64], zero pad
	output logic [87:0]  m_tdata,
	// tolerance register, Q0.16
	input  logic         cfg_wen,
	input  logic [15:0]  cfg_wdata
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SHIFT, ST_WLOAD, ST_K_ISSUE, ST_K_WAIT, ST_K_SCALE,
		ST_CHOOSE, ST_INFL_WAIT, ST_INFL_DONE, ST_FLIP, ST_FLIP_DONE,
		ST_NEWT_INIT, ST_NEWT, ST_NEWT_SLOPE, ST_NEWT_CUBIC, ST_NEWT_DIV,
		ST_ENDP, ST_ENDP_Q1, ST_ENDP_QE, ST_HORN_ISSUE, ST_HORN_WAIT,
		ST_FIN_TSQ, ST_FIN_TSQ_WAIT, ST_FIN_A, ST_FIN_A_WAIT, ST_FIN_B,
		ST_FIN_B_WAIT, ST_FIN_SAT, ST_OUT
	} state_t;

	state_t                 state_q, ret_q;
	logic [TOL_W-1:0]       tolerance_q;

	// per-item working set
	logic signed [V_W-1:0]  v_q [6];    // A.x A.y B.x B.y V.x V.y
	logic signed [W_W-1:0]  w_q [6];    // same, scaled down
	logic [2:0]             s_q;        // scale shift
	word_t                  k_q [4];    // cubic coefficients a b c d
	logic [3:0]             pidx_q;     // coefficient product step
	logic                   from_one_q;
	logic [T_W-1:0]         t_q;
	logic [N_W-1:0]         n_q;        // Newton updates done
	word_t                  d2_q;
	logic                   d1neg_q;
	word_t                  q1_q;
	logic [T_W-1:0]         tsq_q;
	logic                   lane_q;
	logic [31:0]            out_x_q, out_y_q;
	logic [16:0]            out_t_q;

	// Horner engine
	poly_t                  kind_q;
	logic [T_W-1:0]         ht_q;
	logic [2:0]             hidx_q;
	word_t                  acc_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	qbn_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	qbn_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	function automatic logic signed [W_W-1:0] shrmag(input logic signed [V_W-1:0] x,
			input logic [2:0] s);
		logic [V_W-1:0] m;
		m = x[V_W-1] ? V_W'(-x) : V_W'(x);
		m = m >> s;
		return x[V_W-1] ? -W_W'(m) : W_W'(m);
	endfunction

	function automatic logic [31:0] sat32(input word_t x);
		logic [31:0] r;
		if (x > word_t'(64'sh7FFF_FFFF))
			r = 32'h7FFF_FFFF;
		else if (x < -word_t'(64'sh8000_0000))
			r = 32'h8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

	// ---- combinational helpers ------------------------------------------
	logic                  over_any;
	logic signed [W_W-1:0] opa, opb, opb_abs;
	logic [1:0]            p_kidx;
	logic                  p_dbl;
	word_t                 prod_s, sp;
	logic [2:0]            hidx_nx;
	word_t                 coef_nx;
	word_t                 k1abs, k0x3;
	logic                  choose_div;
	logic                  newt_stop;
	logic signed [NT_W-1:0] nt;
	logic [Q_W-1:0]        tol_t;
	logic signed [V_W-1:0] vsel_a, vsel_b;

	always_comb begin
		logic [V_W-1:0] m;
		over_any = 1'b0;
		for (int i = 0; i < 6; i++) begin
			m = v_q[i][V_W-1] ? V_W'(-v_q[i]) : V_W'(v_q[i]);
			if ((m >> s_q) > (V_W'(1) << LIMIT_LOG2))
				over_any = 1'b1;
		end
	end

	// coefficient products: a=|A|^2, b=A.B (x3 later), c=A.V+2|B|^2, d=B.V
	always_comb begin
		opa    = w_q[0];
		opb    = w_q[0];
		p_kidx = 2'd0;
		p_dbl  = 1'b0;
		unique case (pidx_q)
			4'd0:    begin opa = w_q[0]; opb = w_q[0]; p_kidx = 2'd0; end
			4'd1:    begin opa = w_q[1]; opb = w_q[1]; p_kidx = 2'd0; end
			4'd2:    begin opa = w_q[0]; opb = w_q[2]; p_kidx = 2'd1; end
			4'd3:    begin opa = w_q[1]; opb = w_q[3]; p_kidx = 2'd1; end
			4'd4:    begin opa = w_q[0]; opb = w_q[4]; p_kidx = 2'd2; end
			4'd5:    begin opa = w_q[1]; opb = w_q[5]; p_kidx = 2'd2; end
			4'd6:    begin opa = w_q[2]; opb = w_q[2]; p_kidx = 2'd2; p_dbl = 1'b1; end
			4'd7:    begin opa = w_q[3]; opb = w_q[3]; p_kidx = 2'd2; p_dbl = 1'b1; end
			4'd8:    begin opa = w_q[2]; opb = w_q[4]; p_kidx = 2'd3; end
			4'd9:    begin opa = w_q[3]; opb = w_q[5]; p_kidx = 2'd3; end
			default: begin opa = w_q[0]; opb = w_q[0]; p_kidx = 2'd0; end
		endcase
	end

	assign opb_abs = opb[W_W-1] ? -opb : opb;
	assign prod_s  = mul_rsp.neg ? -word_t'(mul_rsp.mag) : word_t'(mul_rsp.mag);
	assign sp      = p_dbl ? (prod_s <<< 1) : prod_s;
	assign hidx_nx = hidx_q + 3'd1;
	assign coef_nx = horner_coef(kind_q, hidx_nx, k_q[0], k_q[1], k_q[2], k_q[3]);
	assign k1abs   = -k_q[1];
	assign k0x3    = k_q[0] + (k_q[0] <<< 1);
	assign choose_div = (k_q[0] != '0) && k_q[1][63] && (k1abs < k0x3);
	// stop when f(t) has the sign that means we are already past the minimum
	assign newt_stop  = ((acc_q <= 0) == from_one_q);
	assign nt = d1neg_q ? (NT_W'(t_q) + NT_W'(div_rsp.quot))
	                    : (NT_W'(t_q) - NT_W'(div_rsp.quot));
	assign tol_t  = Q_W'((32'(tolerance_q) >> FMT_DN) << FMT_UP);
	assign vsel_a = lane_q ? v_q[1] : v_q[0];
	assign vsel_b = lane_q ? v_q[3] : v_q[2];

	always_comb begin
		mul_req = '0;
		unique case (state_q)
			ST_K_ISSUE: begin
				mul_req.start = 1'b1;
				mul_req.a     = 64'(opa);
				mul_req.b     = 32'(opb_abs);
				mul_req.neg   = opb[W_W-1];
			end
			ST_HORN_ISSUE: begin
				mul_req.start = 1'b1;
				mul_req.a     = acc_q;
				mul_req.b     = 32'(ht_q);
				mul_req.shr   = 1'b1;
			end
			ST_FIN_TSQ: begin
				mul_req.start = 1'b1;
				mul_req.a     = word_t'(64'(t_q));
				mul_req.b     = 32'(t_q);
				mul_req.shr   = 1'b1;
			end
			ST_FIN_A: begin
				mul_req.start = 1'b1;
				mul_req.a     = 64'(vsel_a);
				mul_req.b     = 32'(tsq_q);
				mul_req.shr   = 1'b1;
			end
			ST_FIN_B: begin
				mul_req.start = 1'b1;
				mul_req.a     = 64'(vsel_b) <<< 1;
				mul_req.b     = 32'(t_q);
				mul_req.shr   = 1'b1;
			end
			default: mul_req = '0;
		endcase
	end

	always_comb begin
		div_req = '0;
		if (state_q == ST_CHOOSE && choose_div) begin
			div_req.start = 1'b1;
			div_req.num   = 64'(k1abs);
			div_req.den   = 64'(k0x3);
		end else if (state_q == ST_NEWT_CUBIC && !newt_stop) begin
			div_req.start = 1'b1;
			div_req.num   = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
			div_req.den   = 64'(d2_q);
		end
	end

	// ---- configuration ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tolerance_q <= TOL_W'(16);
		else if (cfg_wen)
			tolerance_q <= cfg_wdata;
	end

	// ---- sequencer -------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ret_q      <= ST_IDLE;
			s_q        <= '0;
			pidx_q     <= '0;
			n_q        <= '0;
			hidx_q     <= '0;
			lane_q     <= 1'b0;
			from_one_q <= 1'b0;
			kind_q     <= POLY_CUBIC;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						for (int i = 0; i < 2; i++) begin
							v_q[i] <= V_W'($signed(s_tdata[64 + 32*i +: 32]))
							        - (V_W'($signed(s_tdata[128 + 32*i +: 32])) <<< 1)
							        + V_W'($signed(s_tdata[192 + 32*i +: 32]));
							v_q[2+i] <= V_W'($signed(s_tdata[128 + 32*i +: 32]))
							          - V_W'($signed(s_tdata[64 + 32*i +: 32]));
							v_q[4+i] <= V_W'($signed(s_tdata[64 + 32*i +: 32]))
							          - V_W'($signed(s_tdata[32*i +: 32]));
						end
						s_q     <= '0;
						state_q <= ST_SHIFT;
					end
				end
				// smallest shift that brings every component within 2^27
				ST_SHIFT: begin
					if (over_any)
						s_q <= s_q + 3'd1;
					else
						state_q <= ST_WLOAD;
				end
				ST_WLOAD: begin
					for (int i = 0; i < 6; i++)
						w_q[i] <= shrmag(v_q[i], s_q);
					for (int i = 0; i < 4; i++)
						k_q[i] <= '0;
					pidx_q  <= '0;
					state_q <= ST_K_ISSUE;
				end
				ST_K_ISSUE: state_q <= ST_K_WAIT;
				ST_K_WAIT: begin
					if (mul_rsp.done) begin
						k_q[p_kidx] <= k_q[p_kidx] + sp;
						pidx_q      <= pidx_q + 4'd1;
						state_q     <= (pidx_q == 4'(K_PRODUCTS - 1)) ? ST_K_SCALE : ST_K_ISSUE;
					end
				end
				ST_K_SCALE: begin
					k_q[1]  <= k_q[1] + (k_q[1] <<< 1);
					state_q <= ST_CHOOSE;
				end
				// start choice from the inflection point -b/(3a)
				ST_CHOOSE: begin
					if (k_q[0] == '0) begin
						from_one_q <= 1'b0;
						state_q    <= ST_FLIP;
					end else if (!k_q[1][63]) begin
						from_one_q <= 1'b1;
						state_q    <= ST_FLIP;
					end else if (choose_div) begin
						state_q <= ST_INFL_WAIT;
					end else begin
						from_one_q <= 1'b0;
						state_q    <= ST_FLIP;
					end
				end
				ST_INFL_WAIT: begin
					if (div_rsp.done) begin
						kind_q  <= POLY_CUBIC;
						ht_q    <= div_rsp.quot[T_W-1:0];
						hidx_q  <= '0;
						acc_q   <= horner_coef(POLY_CUBIC, 3'd0, k_q[0], k_q[1], k_q[2], k_q[3]);
						ret_q   <= ST_INFL_DONE;
						state_q <= ST_HORN_ISSUE;
					end
				end
				ST_INFL_DONE: begin
					from_one_q <= acc_q[63];
					state_q    <= ST_FLIP;
				end
				ST_FLIP: begin
					if (from_one_q) begin
						kind_q  <= POLY_CUBIC;
						ht_q    <= T_ONE;
						hidx_q  <= '0;
						acc_q   <= horner_coef(POLY_CUBIC, 3'd0, k_q[0], k_q[1], k_q[2], k_q[3]);
						ret_q   <= ST_FLIP_DONE;
						state_q <= ST_HORN_ISSUE;
					end else begin
						if (k_q[3] > 0)
							from_one_q <= 1'b1;
						state_q <= ST_NEWT_INIT;
					end
				end
				ST_FLIP_DONE: begin
					if (acc_q[63])
						from_one_q <= 1'b0;
					state_q <= ST_NEWT_INIT;
				end
				ST_NEWT_INIT: begin
					t_q     <= from_one_q ? T_ONE : '0;
					n_q     <= '0;
					state_q <= ST_NEWT;
				end
				ST_NEWT: begin
					if (n_q == N_W'(MAX_NEWTON_STEPS)) begin
						state_q <= ST_ENDP;
					end else begin
						kind_q  <= POLY_SLOPE;
						ht_q    <= t_q;
						hidx_q  <= '0;
						acc_q   <= horner_coef(POLY_SLOPE, 3'd0, k_q[0], k_q[1], k_q[2], k_q[3]);
						ret_q   <= ST_NEWT_SLOPE;
						state_q <= ST_HORN_ISSUE;
					end
				end
				ST_NEWT_SLOPE: begin
					if (acc_q <= 0) begin
						state_q <= ST_ENDP;
					end else begin
						d2_q    <= acc_q;
						kind_q  <= POLY_CUBIC;
						ht_q    <= t_q;
						hidx_q  <= '0;
						acc_q   <= horner_coef(POLY_CUBIC, 3'd0, k_q[0], k_q[1], k_q[2], k_q[3]);
						ret_q   <= ST_NEWT_CUBIC;
						state_q <= ST_HORN_ISSUE;
					end
				end
				ST_NEWT_CUBIC: begin
					if (newt_stop) begin
						state_q <= ST_ENDP;
					end else begin
						d1neg_q <= acc_q[63];
						state_q <= ST_NEWT_DIV;
					end
				end
				// unclamped step size equals the quotient itself
				ST_NEWT_DIV: begin
					if (div_rsp.done) begin
						n_q <= n_q + 1'b1;
						if (nt < 0) begin
							t_q     <= '0;
							state_q <= ST_ENDP;
						end else if (nt > NT_W'(T_ONE)) begin
							t_q     <= T_ONE;
							state_q <= ST_ENDP;
						end else begin
							t_q     <= nt[T_W-1:0];
							state_q <= (div_rsp.quot <= tol_t) ? ST_ENDP : ST_NEWT;
						end
					end
				end
				// compare against the endpoint the iteration did not start from
				ST_ENDP: begin
					kind_q  <= POLY_QUART;
					ht_q    <= t_q;
					hidx_q  <= '0;
					acc_q   <= horner_coef(POLY_QUART, 3'd0, k_q[0], k_q[1], k_q[2], k_q[3]);
					ret_q   <= ST_ENDP_Q1;
					state_q <= ST_HORN_ISSUE;
				end
				ST_ENDP_Q1: begin
					if (from_one_q) begin
						if (acc_q > 0)
							t_q <= '0;
						state_q <= ST_FIN_TSQ;
					end else begin
						q1_q    <= acc_q;
						kind_q  <= POLY_QUART;
						ht_q    <= T_ONE;
						hidx_q  <= '0;
						acc_q   <= horner_coef(POLY_QUART, 3'd0, k_q[0], k_q[1], k_q[2], k_q[3]);
						ret_q   <= ST_ENDP_QE;
						state_q <= ST_HORN_ISSUE;
					end
				end
				ST_ENDP_QE: begin
					if (q1_q > acc_q)
						t_q <= T_ONE;
					state_q <= ST_FIN_TSQ;
				end
				// Horner: acc = acc*t + next coefficient
				ST_HORN_ISSUE: state_q <= ST_HORN_WAIT;
				ST_HORN_WAIT: begin
					if (mul_rsp.done) begin
						acc_q  <= prod_s + coef_nx;
						hidx_q <= hidx_nx;
						state_q <= (hidx_nx == poly_degree(kind_q)) ? ret_q : ST_HORN_ISSUE;
					end
				end
				// vector = A t^2 + 2B t + V, per lane
				ST_FIN_TSQ: state_q <= ST_FIN_TSQ_WAIT;
				ST_FIN_TSQ_WAIT: begin
					if (mul_rsp.done) begin
						tsq_q   <= mul_rsp.mag[T_W-1:0];
						lane_q  <= 1'b0;
						acc_q   <= 64'(v_q[4]);
						state_q <= ST_FIN_A;
					end
				end
				ST_FIN_A: state_q <= ST_FIN_A_WAIT;
				ST_FIN_A_WAIT: begin
					if (mul_rsp.done) begin
						acc_q   <= acc_q + prod_s;
						state_q <= ST_FIN_B;
					end
				end
				ST_FIN_B: state_q <= ST_FIN_B_WAIT;
				ST_FIN_B_WAIT: begin
					if (mul_rsp.done) begin
						acc_q   <= acc_q + prod_s;
						state_q <= ST_FIN_SAT;
					end
				end
				ST_FIN_SAT: begin
					if (!lane_q) begin
						out_x_q <= sat32(acc_q);
						lane_q  <= 1'b1;
						acc_q   <= 64'(v_q[5]);
						state_q <= ST_FIN_A;
					end else begin
						out_y_q <= sat32(acc_q);
						out_t_q <= 17'((32'(t_q) >> FMT_UP) << FMT_DN);
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {7'b0, out_t_q, out_y_q, out_x_q};

	// ---- checks ----------------------------------------------------------
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while a result is pending");

	a_param_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[80:64] <= 17'h10000))
		else $error("curve_param beyond one");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= N_W'(MAX_NEWTON_STEPS))
		else $error("Newton step count overran");

	a_return_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> s_tready)
		else $error("not ready after result taken");

endmodule
`default_nettype wire

/* rtl/qbn_mul.sv */
// Shared multiply unit: sign(a)^neg times (|a|*b >> FRAC_BITS or 0), from two 32x32 partials.
// Takes a new request only when idle. Returns magnitude and sign; depends on qbn_pkg.
`default_nettype none
module qbn_mul
	import qbn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_SUM} mstate_t;

	mstate_t     state_q;
	logic [31:0] a_lo_q, a_hi_q, b_q;
	logic        neg_q, shr_q, done_q;
	logic [63:0] lo_s1, hi_s2, mag_q;
	logic [63:0] a_abs;
	logic [95:0] full;

	assign a_abs = req.a[63] ? 64'(-req.a) : 64'(req.a);
	assign full  = {hi_s2, 32'b0} + 96'(lo_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						a_lo_q  <= a_abs[31:0];
						a_hi_q  <= a_abs[63:32];
						b_q     <= req.b;
						neg_q   <= req.a[63] ^ req.neg;
						shr_q   <= req.shr;
						state_q <= M_LO;
					end
				end
				M_LO: begin
					lo_s1   <= 64'(a_lo_q) * 64'(b_q);
					state_q <= M_HI;
				end
				M_HI: begin
					hi_s2   <= 64'(a_hi_q) * 64'(b_q);
					state_q <= M_SUM;
				end
				M_SUM: begin
					mag_q   <= shr_q ? full[FRAC_BITS +: 64] : full[63:0];
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.mag  = mag_q;
	assign rsp.neg  = neg_q;

endmodule
`default_nettype wire

/* rtl/qbn_div.sv */
// Restoring divider: num/den with FRAC_BITS fraction bits, truncated, saturated at 2.
// One quotient bit per cycle; depends on qbn_pkg.
`default_nettype none
module qbn_div
	import qbn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	typedef enum logic [1:0] {D_IDLE, D_CHECK, D_ITER} dstate_t;

	dstate_t              state_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [63:0]          r_q, den_q;
	logic [T_W-1:0]       q_q;
	logic [Q_W-1:0]       quot_q;
	logic                 done_q;
	logic [64:0]          trial;
	logic                 qbit;

	assign trial = {1'b0, r_q} - {1'b0, den_q};
	assign qbit  = ~trial[64];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						r_q     <= req.num;
						den_q   <= req.den;
						state_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					if ({1'b0, r_q} >= {den_q, 1'b0}) begin
						quot_q  <= Q_W'(1) << (FRAC_BITS + 1);
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						q_q     <= '0;
						cnt_q   <= '0;
						state_q <= D_ITER;
					end
				end
				D_ITER: begin
					q_q <= {q_q[T_W-2:0], qbit};
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						quot_q  <= Q_W'({q_q[T_W-2:0], qbit});
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						r_q   <= (qbit ? trial[63:0] : r_q) << 1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule
`default_nettype wire
